FILE: src/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// Used by lobm_ctrl, lobm_datapath and limit_order_book_matcher; no dependencies.
package lobm_pkg;

    // Table size and derived widths.
    localparam int ORDER_SLOTS = 32;
    localparam int SLOT_W = $clog2(ORDER_SLOTS);

    // A match emits at most FILL_MAX fills before its done item.
    localparam int FILL_W = 6;
    localparam logic [FILL_W-1:0] FILL_MAX = 6'd63;

    // Operation codes of an input item.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MATCH = 2'd2;
    localparam logic [1:0] OP_SNAPSHOT = 2'd3;

    // Kinds of result item.
    localparam logic [2:0] KIND_FILL = 3'd0;
    localparam logic [2:0] KIND_DONE = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_ADD = 3'd3;
    localparam logic [2:0] KIND_BID = 3'd4;
    localparam logic [2:0] KIND_ASK = 3'd5;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CANCEL,
        ST_MAT_START,
        ST_MAT_SCAN,
        ST_MAT_FILL,
        ST_SNAP_BEST,
        ST_SNAP_SUM
    } state_t;

    // Which result item the datapath builds this cycle.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ADD,
        EMIT_CANCEL_HIT,
        EMIT_CANCEL_MISS,
        EMIT_FILL,
        EMIT_DONE,
        EMIT_SNAP
    } emit_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic  load;
        logic  idx_inc;
        logic  match_eval;
        logic  snap_eval;
        logic  sum_eval;
        logic  snap_next;
        emit_t emit;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic cancel_hit;
        logic best_found;
        logic rest_zero;
        logic fill_limit;
        logic snap_side;
    } stat_t;

endpackage

FILE: src/lobm_ctrl.sv
// Controller state machine of the limit order book matcher.
// Depends on lobm_pkg; drives lobm_datapath through cmd_t and reads stat_t.
module lobm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  lobm_pkg::stat_t  stat,
    output lobm_pkg::cmd_t   cmd,
    output logic             busy
);

    lobm_pkg::state_t state_reg;
    lobm_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lobm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != lobm_pkg::ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.emit = lobm_pkg::EMIT_NONE;
        unique case (state_reg)
            lobm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        lobm_pkg::OP_ADD:    state_next = lobm_pkg::ST_ADD;
                        lobm_pkg::OP_CANCEL: state_next = lobm_pkg::ST_CANCEL;
                        lobm_pkg::OP_MATCH:  state_next = lobm_pkg::ST_MAT_START;
                        default:             state_next = lobm_pkg::ST_SNAP_BEST;
                    endcase
                end
            end
            lobm_pkg::ST_ADD:
            begin
                cmd.emit = lobm_pkg::EMIT_ADD;
                state_next = lobm_pkg::ST_IDLE;
            end
            lobm_pkg::ST_CANCEL:
            begin
                if (stat.cancel_hit)
                begin
                    cmd.emit = lobm_pkg::EMIT_CANCEL_HIT;
                    state_next = lobm_pkg::ST_IDLE;
                end
                else if (stat.scan_last)
                begin
                    cmd.emit = lobm_pkg::EMIT_CANCEL_MISS;
                    state_next = lobm_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            lobm_pkg::ST_MAT_START:
            begin
                if (stat.rest_zero || stat.fill_limit)
                begin
                    cmd.emit = lobm_pkg::EMIT_DONE;
                    state_next = lobm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lobm_pkg::ST_MAT_SCAN;
                end
            end
            lobm_pkg::ST_MAT_SCAN:
            begin
                cmd.match_eval = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = lobm_pkg::ST_MAT_FILL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            lobm_pkg::ST_MAT_FILL:
            begin
                if (stat.best_found)
                begin
                    cmd.emit = lobm_pkg::EMIT_FILL;
                    state_next = lobm_pkg::ST_MAT_START;
                end
                else
                begin
                    cmd.emit = lobm_pkg::EMIT_DONE;
                    state_next = lobm_pkg::ST_IDLE;
                end
            end
            lobm_pkg::ST_SNAP_BEST:
            begin
                cmd.snap_eval = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = lobm_pkg::ST_SNAP_SUM;
                end
                cmd.idx_inc = 1'b1;
            end
            default:
            begin
                // Level sum; the last slot also emits the level item.
                cmd.sum_eval = 1'b1;
                cmd.idx_inc = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.emit = lobm_pkg::EMIT_SNAP;
                    if (stat.snap_side)
                    begin
                        state_next = lobm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.snap_next = 1'b1;
                        state_next = lobm_pkg::ST_SNAP_BEST;
                    end
                end
            end
        endcase
    end

endmodule

FILE: src/lobm_datapath.sv
// Datapath of the limit order book matcher: slot table, scan pointer,
// best-entry registers and result register. Depends on lobm_pkg.
module lobm_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  lobm_pkg::cmd_t      cmd,
    output lobm_pkg::stat_t     stat,
    input  logic                side,
    input  logic [31:0]         price,
    input  logic [31:0]         quantity,
    input  logic [63:0]         order_id,
    output logic                result_valid,
    output logic [2:0]          kind,
    output logic [63:0]         order_id_res,
    output logic [31:0]         price_res,
    output logic [31:0]         quantity_res,
    output logic                flag,
    output logic                last
);

    localparam int N = lobm_pkg::ORDER_SLOTS;
    localparam int W = lobm_pkg::SLOT_W;

    // Slot table; only valid entries are ever used.
    logic [N-1:0]  valid_reg;
    logic          slot_side_reg [N];
    logic [31:0]   slot_price_reg [N];
    logic [31:0]   slot_qty_reg [N];
    logic [63:0]   slot_id_reg [N];
    logic [31:0]   slot_arr_reg [N];
    logic [31:0]   arrival_reg;

    // Latched item and scan state.
    logic                        side_reg;
    logic [31:0]                 price_reg;
    logic [31:0]                 rest_reg;
    logic [63:0]                 id_reg;
    logic [W-1:0]                idx_reg;
    logic                        found_reg;
    logic [W-1:0]                best_idx_reg;
    logic [31:0]                 best_price_reg;
    logic [31:0]                 best_age_reg;
    logic [31:0]                 best_qty_reg;
    logic [63:0]                 best_id_reg;
    logic [31:0]                 sum_reg;
    logic                        snap_side_reg;
    logic [lobm_pkg::FILL_W-1:0] fill_cnt_reg;

    // Current slot under the scan pointer.
    logic        cur_valid;
    logic        cur_side;
    logic [31:0] cur_price;
    logic [31:0] cur_qty;
    logic [31:0] cur_age;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_side = slot_side_reg[idx_reg];
    assign cur_price = slot_price_reg[idx_reg];
    assign cur_qty = slot_qty_reg[idx_reg];
    assign cur_age = arrival_reg - slot_arr_reg[idx_reg];

    // First free slot for an add.
    logic         full;
    logic [W-1:0] free_idx;

    always_comb
    begin
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = W'(i);
            end
        end
    end

    assign full = &valid_reg;

    // Match candidate: opposite side, crossing the limit, better than best.
    logic opp;
    logic crosses;
    logic match_cand;
    logic match_better;

    assign opp = ~side_reg;
    assign crosses = side_reg ? (cur_price >= price_reg) : (cur_price <= price_reg);

    always_comb
    begin
        if (!found_reg)
        begin
            match_better = 1'b1;
        end
        else if (cur_price != best_price_reg)
        begin
            match_better = opp ? (cur_price < best_price_reg) : (cur_price > best_price_reg);
        end
        else
        begin
            match_better = (cur_age > best_age_reg);
        end
    end

    assign match_cand = cur_valid && (cur_side == opp) && crosses && match_better;

    // Snapshot candidate and saturating level sum.
    logic        snap_cand;
    logic        sum_hit;
    logic [32:0] sum_wide;

    assign snap_cand = cur_valid && (cur_side == snap_side_reg) &&
                       (!found_reg || (snap_side_reg ? (cur_price < best_price_reg)
                                                     : (cur_price > best_price_reg)));
    assign sum_hit = cur_valid && (cur_side == snap_side_reg) && (cur_price == best_price_reg);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, cur_qty};

    // Fill slice.
    logic [31:0] fill;
    logic [31:0] left_qty;

    assign fill = (best_qty_reg < rest_reg) ? best_qty_reg : rest_reg;
    assign left_qty = best_qty_reg - fill;

    // Status.
    assign stat.scan_last = (idx_reg == W'(N - 1));
    assign stat.cancel_hit = cur_valid && (slot_id_reg[idx_reg] == id_reg);
    assign stat.best_found = found_reg;
    assign stat.rest_zero = (rest_reg == '0);
    assign stat.fill_limit = (fill_cnt_reg == lobm_pkg::FILL_MAX);
    assign stat.snap_side = snap_side_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            arrival_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            fill_cnt_reg <= '0;
            snap_side_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= (cmd.emit != lobm_pkg::EMIT_NONE);
            if (cmd.load || cmd.snap_next)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.emit == lobm_pkg::EMIT_FILL)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= (idx_reg == W'(N - 1)) ? '0 : idx_reg + 1'b1;
                end
                if ((cmd.match_eval && match_cand) || (cmd.snap_eval && snap_cand))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                fill_cnt_reg <= '0;
                snap_side_reg <= 1'b0;
            end
            if (cmd.snap_next)
            begin
                snap_side_reg <= 1'b1;
            end
            unique case (cmd.emit)
                lobm_pkg::EMIT_ADD:
                begin
                    if (!full)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        arrival_reg <= arrival_reg + 32'd1;
                    end
                end
                lobm_pkg::EMIT_CANCEL_HIT:
                begin
                    valid_reg[idx_reg] <= 1'b0;
                end
                lobm_pkg::EMIT_FILL:
                begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (left_qty == '0)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Table payload, item latch, best entry and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            side_reg <= side;
            price_reg <= price;
            rest_reg <= quantity;
            id_reg <= order_id;
        end
        // The level sum restarts for each side of a snapshot.
        if (cmd.load || cmd.snap_next)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_eval && sum_hit)
        begin
            sum_reg <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        end
        if ((cmd.match_eval && match_cand) || (cmd.snap_eval && snap_cand))
        begin
            best_idx_reg <= idx_reg;
            best_price_reg <= cur_price;
            best_age_reg <= cur_age;
            best_qty_reg <= cur_qty;
            best_id_reg <= slot_id_reg[idx_reg];
        end
        if (cmd.emit == lobm_pkg::EMIT_ADD && !full)
        begin
            slot_side_reg[free_idx] <= side_reg;
            slot_price_reg[free_idx] <= price_reg;
            slot_qty_reg[free_idx] <= rest_reg;
            slot_id_reg[free_idx] <= id_reg;
            slot_arr_reg[free_idx] <= arrival_reg;
        end
        if (cmd.emit == lobm_pkg::EMIT_FILL)
        begin
            slot_qty_reg[best_idx_reg] <= left_qty;
            rest_reg <= rest_reg - fill;
        end

        // Result item.
        unique case (cmd.emit)
            lobm_pkg::EMIT_ADD:
            begin
                kind <= lobm_pkg::KIND_ADD;
                order_id_res <= id_reg;
                price_res <= price_reg;
                quantity_res <= rest_reg;
                flag <= !full;
                last <= 1'b1;
            end
            lobm_pkg::EMIT_CANCEL_HIT:
            begin
                kind <= lobm_pkg::KIND_CANCEL;
                order_id_res <= id_reg;
                price_res <= cur_price;
                quantity_res <= cur_qty;
                flag <= 1'b1;
                last <= 1'b1;
            end
            lobm_pkg::EMIT_CANCEL_MISS:
            begin
                kind <= lobm_pkg::KIND_CANCEL;
                order_id_res <= id_reg;
                price_res <= '0;
                quantity_res <= '0;
                flag <= 1'b0;
                last <= 1'b1;
            end
            lobm_pkg::EMIT_FILL:
            begin
                kind <= lobm_pkg::KIND_FILL;
                order_id_res <= best_id_reg;
                price_res <= best_price_reg;
                quantity_res <= fill;
                flag <= 1'b0;
                last <= 1'b0;
            end
            lobm_pkg::EMIT_DONE:
            begin
                kind <= lobm_pkg::KIND_DONE;
                order_id_res <= '0;
                price_res <= price_reg;
                quantity_res <= rest_reg;
                flag <= 1'b0;
                last <= 1'b1;
            end
            lobm_pkg::EMIT_SNAP:
            begin
                // The level sum includes the last slot when it belongs to the level.
                kind <= snap_side_reg ? lobm_pkg::KIND_ASK : lobm_pkg::KIND_BID;
                order_id_res <= '0;
                price_res <= found_reg ? best_price_reg : '0;
                if (!found_reg)
                begin
                    quantity_res <= '0;
                end
                else if (sum_hit)
                begin
                    quantity_res <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                end
                else
                begin
                    quantity_res <= sum_reg;
                end
                flag <= found_reg;
                last <= snap_side_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: src/limit_order_book_matcher.sv
// Top level of the limit order book matcher.
// Depends on lobm_pkg, lobm_ctrl and lobm_datapath.
//
// Price-time priority order table of lobm_pkg::ORDER_SLOTS slots. An item is
// taken when start is high and busy is low; each result item appears for one
// cycle with result_valid high and cannot be held off, so the receiver must
// take it then. The table is searched one slot per cycle: an add needs no
// search, a cancel stops at the matching order or the last slot, a snapshot
// makes a best pass and a sum pass per side, and a match makes a scan pass per
// fill and emits the done item when the quantity or the fill count runs out or
// no crossing order is left. The last result of an item carries last = 1, and
// busy is low again in the cycle it is shown.
module limit_order_book_matcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] quantity,
    input  logic [63:0] order_id,
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic [63:0] order_id_res,
    output logic [31:0] price_res,
    output logic [31:0] quantity_res,
    output logic        flag,
    output logic        last
);

    lobm_pkg::cmd_t  cmd;
    lobm_pkg::stat_t stat;

    // Sequencer.
    lobm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Slot table and result path.
    lobm_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .side         (side),
        .price        (price),
        .quantity     (quantity),
        .order_id     (order_id),
        .result_valid (result_valid),
        .kind         (kind),
        .order_id_res (order_id_res),
        .price_res    (price_res),
        .quantity_res (quantity_res),
        .flag         (flag),
        .last         (last)
    );

endmodule
